/* rtl/radial_mesh_vertex_warp_unit_assert.svh */
// assertion macros shared by the rtl
`ifndef RADIAL_MESH_VERTEX_WARP_UNIT_ASSERT_SVH
`define RADIAL_MESH_VERTEX_WARP_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RMVW_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");
`define RMVW_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define RMVW_ASSERT_IMP(lbl, a, c)
`define RMVW_ASSERT_NXT(lbl, a, c)
`endif
`endif

/* rtl/rmvw_pkg.sv */
`default_nettype none
package rmvw_pkg;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_RADIUS      = 3'd3,
    REG_TINT_COLOR  = 3'd4,
    REG_START_PH_X  = 3'd5,
    REG_START_PH_Y  = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MR2,
    ST_MDX,
    ST_MDY,
    ST_MDZ,
    ST_CHECK,
    ST_DIVW,
    ST_SQRT,
    ST_MCOL,
    ST_MPX,
    ST_MPY,
    ST_MWX,
    ST_MWY,
    ST_DIVX,
    ST_DIVY,
    ST_FINAL,
    ST_DONE
  } state_t;

  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [15:0] PHASE_STEP_X = 16'd1024;
  localparam logic [15:0] PHASE_STEP_Y = 16'd512;
  localparam logic [31:0] RGB_MASK     = 32'h00ff_ffff;
  localparam logic [31:0] ALPHA_FULL   = 32'hff00_0000;
  localparam logic [7:0]  BYTE_MAX     = 8'd255;

endpackage
`default_nettype wire

/* rtl/radial_mesh_vertex_warp_unit.sv */
// Radial mesh vertex warp. One vertex request in, one result out. A vertex
// outside the radius goes from the squared distances and the compare straight
// to forming the result; one inside takes multiplier steps for the squared
// radius and distances and one compare step, 17 steps of the weight division,
// 17 steps of the square root, multiplier steps for colour, push and wobble
// products, 2 x 10 steps of the push divisions and one step to form the
// result; a zero radius skips the weight division. All divisions and the
// root run through one shared compare-subtract unit, the products through
// one 17x17 multiplier; the block takes a new request in the cycle after the
// result has been taken.
`default_nettype none
module radial_mesh_vertex_warp_unit #(
  parameter int SCREEN_WIDTH       = 640,
  parameter int SCREEN_HEIGHT      = 480,
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               first_vertex,
  input  wire logic signed [15:0] grid_x,
  input  wire logic signed [15:0] grid_y,
  input  wire logic signed [15:0] grid_z,
  input  wire logic signed [15:0] vert_x,
  input  wire logic signed [15:0] vert_y,
  input  wire logic [31:0]        vert_color,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_vert_x,
  output logic signed [15:0]      out_vert_y,
  output logic signed [15:0]      out_grid_x,
  output logic signed [15:0]      out_grid_y,
  output logic [31:0]             out_color,
  output logic                    inside_res
);

`include "radial_mesh_vertex_warp_unit_assert.svh"

  localparam int IDXW = $clog2(SINE_TABLE_ENTRIES);
  localparam logic signed [16:0] X_HI = 17'(SCREEN_WIDTH * 16);
  localparam logic signed [16:0] Y_HI = 17'(SCREEN_HEIGHT * 16);
  localparam logic signed [15:0] X_EDGE = 16'((SCREEN_WIDTH - 1) * 16);
  localparam logic signed [15:0] Y_EDGE = 16'((SCREEN_HEIGHT - 1) * 16);
  localparam logic signed [15:0] LOW_EDGE = 16'sd16;

  // sine table, magnitude and sign
  logic [14:0] sine_mag [SINE_TABLE_ENTRIES];
  logic        sine_neg [SINE_TABLE_ENTRIES];

  for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_sine
    localparam logic [63:0] GQ = 64'(4 * k) / 64'(SINE_TABLE_ENTRIES);
    localparam logic [63:0] GR = 64'(4 * k) - GQ * 64'(SINE_TABLE_ENTRIES);
    localparam logic [63:0] GT = GQ[0] ? 64'(SINE_TABLE_ENTRIES) - GR : GR;
    localparam logic [63:0] GX = (rmvw_pkg::HALF_PI_Q30 * GT) / 64'(SINE_TABLE_ENTRIES);
    // taylor series of sine in q30, six terms past x
    localparam logic [63:0] GX2 = (GX * GX) >> 30;
    localparam logic [63:0] GT1 = ((GX * GX2) >> 30) / 64'd6;
    localparam logic [63:0] GT2 = ((GT1 * GX2) >> 30) / 64'd20;
    localparam logic [63:0] GT3 = ((GT2 * GX2) >> 30) / 64'd42;
    localparam logic [63:0] GT4 = ((GT3 * GX2) >> 30) / 64'd72;
    localparam logic [63:0] GT5 = ((GT4 * GX2) >> 30) / 64'd110;
    localparam logic [63:0] GT6 = ((GT5 * GX2) >> 30) / 64'd156;
    localparam logic signed [63:0] GS = signed'(GX) - signed'(GT1) + signed'(GT2)
                                      - signed'(GT3) + signed'(GT4) - signed'(GT5)
                                      + signed'(GT6);
    localparam logic [63:0] GP = (GS < 0) ? 64'd0 : unsigned'(GS);
    localparam logic [63:0] GV = (GP + 64'd32768) >> 16;
    localparam logic [63:0] GM = (GV > 64'd16384) ? 64'd16384 : GV;
    assign sine_mag[k] = GM[14:0];
    assign sine_neg[k] = (GQ >= 64'd2);
  end

  // configuration
  logic signed [15:0] center_x, center_y, center_z;
  logic [14:0] radius;
  logic [31:0] tint_color;
  logic [15:0] start_phase_x, start_phase_y;
  logic [15:0] run_phase_x, run_phase_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      radius        <= '0;
      tint_color    <= '0;
      start_phase_x <= '0;
      start_phase_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmvw_pkg::REG_CENTER_X:   center_x      <= cfg_data[15:0];
        rmvw_pkg::REG_CENTER_Y:   center_y      <= cfg_data[15:0];
        rmvw_pkg::REG_CENTER_Z:   center_z      <= cfg_data[15:0];
        rmvw_pkg::REG_RADIUS:     radius        <= cfg_data[14:0];
        rmvw_pkg::REG_TINT_COLOR: tint_color    <= cfg_data;
        rmvw_pkg::REG_START_PH_X: start_phase_x <= cfg_data[15:0];
        rmvw_pkg::REG_START_PH_Y: start_phase_y <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rmvw_pkg::state_t state, state_next;

  // latched request
  logic signed [15:0] gx, gy, vx, vy;
  logic [31:0] col_in;
  logic [15:0] ph_x, ph_y;
  logic signed [16:0] dx, dy, dz;

  // datapath
  logic [29:0] r2;
  logic [33:0] d2, s2;
  logic [16:0] w;
  logic [34:0] rem;
  logic [33:0] res;
  logic [32:0] bitr;
  logic [25:0] dreg;
  logic [16:0] quo;
  logic [4:0]  cnt;
  logic [31:0] col_new;
  logic [24:0] px_num, py_num;
  logic [9:0]  qx;
  logic signed [8:0] wob_x, wob_y;
  logic in_radius;

  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p;
  logic [34:0] sub_op, rem_sub;
  logic        ge;
  logic [16:0] adx, ady, adz;
  logic [IDXW-1:0] idx_x, idx_y;
  logic [7:0] cbyte;
  logic [24:0] cround;
  logic [7:0]  cfade;
  logic [31:0] col_step;
  logic [9:0]  quo_lo;
  logic signed [18:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y;
  logic signed [11:0] push_x, push_y;

  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign adz = dz[16] ? 17'(-dz) : 17'(dz);
  assign idx_x = IDXW'(({16'd0, ph_x} * 32'(SINE_TABLE_ENTRIES)) >> 16);
  assign idx_y = IDXW'(({16'd0, ph_y} * 32'(SINE_TABLE_ENTRIES)) >> 16);
  assign quo_lo = quo[9:0];

  always_comb begin
    case (cnt[1:0])
      2'd0:    cbyte = tint_color[7:0];
      2'd1:    cbyte = tint_color[15:8];
      default: cbyte = tint_color[23:16];
    endcase
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      rmvw_pkg::ST_MR2: begin
        mul_a = {2'b0, radius};
        mul_b = {2'b0, radius};
      end
      rmvw_pkg::ST_MDX: begin
        mul_a = adx;
        mul_b = adx;
      end
      rmvw_pkg::ST_MDY: begin
        mul_a = ady;
        mul_b = ady;
      end
      rmvw_pkg::ST_MDZ: begin
        mul_a = adz;
        mul_b = adz;
      end
      rmvw_pkg::ST_MCOL: begin
        mul_a = {9'd0, rmvw_pkg::BYTE_MAX - cbyte};
        mul_b = w;
      end
      rmvw_pkg::ST_MPX: begin
        mul_a = adx;
        mul_b = w;
      end
      rmvw_pkg::ST_MPY: begin
        mul_a = ady;
        mul_b = w;
      end
      rmvw_pkg::ST_MWX: begin
        mul_a = {2'b0, sine_mag[idx_x]};
        mul_b = w;
      end
      rmvw_pkg::ST_MWY: begin
        mul_a = {2'b0, sine_mag[idx_y]};
        mul_b = w;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign cround = 25'(mul_p) + 25'd65535;
  assign cfade  = rmvw_pkg::BYTE_MAX - cround[23:16];
  always_comb begin
    col_step = col_new;
    case (cnt[1:0])
      2'd0:    col_step[7:0]   = cfade;
      2'd1:    col_step[15:8]  = cfade;
      default: col_step[23:16] = cfade;
    endcase
  end

  // shared compare-subtract unit
  always_comb begin
    case (state)
      rmvw_pkg::ST_DIVW: sub_op = {5'd0, r2};
      rmvw_pkg::ST_SQRT: sub_op = {1'b0, res} + {2'b0, bitr};
      rmvw_pkg::ST_DIVX,
      rmvw_pkg::ST_DIVY: sub_op = {9'd0, dreg};
      default:           sub_op = '0;
    endcase
  end
  assign ge      = rem >= sub_op;
  assign rem_sub = rem - sub_op;

  // final position
  assign push_x = dx[16] ? -12'(signed'({1'b0, qx})) : 12'(signed'({1'b0, qx}));
  assign push_y = dy[16] ? -12'(signed'({1'b0, quo_lo})) : 12'(signed'({1'b0, quo_lo}));
  assign sum_x = in_radius ? 19'(vx) + 19'(push_x) + 19'(wob_x) : 19'(vx);
  assign sum_y = in_radius ? 19'(vy) + 19'(push_y) + 19'(wob_y) : 19'(vy);
  assign sat_x = (sum_x > 19'sd32767) ? 16'sd32767 :
                 (sum_x < -19'sd32768) ? -16'sd32768 : sum_x[15:0];
  assign sat_y = (sum_y > 19'sd32767) ? 16'sd32767 :
                 (sum_y < -19'sd32768) ? -16'sd32768 : sum_y[15:0];

  assign in_ready  = (state == rmvw_pkg::ST_IDLE);
  assign out_valid = (state == rmvw_pkg::ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmvw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rmvw_pkg::ST_IDLE:  if (in_valid) state_next = rmvw_pkg::ST_MR2;
      rmvw_pkg::ST_MR2:   state_next = rmvw_pkg::ST_MDX;
      rmvw_pkg::ST_MDX:   state_next = rmvw_pkg::ST_MDY;
      rmvw_pkg::ST_MDY:   state_next = rmvw_pkg::ST_MDZ;
      rmvw_pkg::ST_MDZ:   state_next = rmvw_pkg::ST_CHECK;
      rmvw_pkg::ST_CHECK: begin
        if (d2 > {4'd0, r2}) begin
          state_next = rmvw_pkg::ST_FINAL;
        end else if (r2 == '0) begin
          state_next = rmvw_pkg::ST_SQRT;
        end else begin
          state_next = rmvw_pkg::ST_DIVW;
        end
      end
      rmvw_pkg::ST_DIVW:  if (cnt == '0) state_next = rmvw_pkg::ST_SQRT;
      rmvw_pkg::ST_SQRT:  if (cnt == '0) state_next = rmvw_pkg::ST_MCOL;
      rmvw_pkg::ST_MCOL:  if (cnt == '0) state_next = rmvw_pkg::ST_MPX;
      rmvw_pkg::ST_MPX:   state_next = rmvw_pkg::ST_MPY;
      rmvw_pkg::ST_MPY:   state_next = rmvw_pkg::ST_MWX;
      rmvw_pkg::ST_MWX:   state_next = rmvw_pkg::ST_MWY;
      rmvw_pkg::ST_MWY: begin
        state_next = (s2 == '0) ? rmvw_pkg::ST_FINAL : rmvw_pkg::ST_DIVX;
      end
      rmvw_pkg::ST_DIVX:  if (cnt == '0) state_next = rmvw_pkg::ST_DIVY;
      rmvw_pkg::ST_DIVY:  if (cnt == '0) state_next = rmvw_pkg::ST_FINAL;
      rmvw_pkg::ST_FINAL: state_next = rmvw_pkg::ST_DONE;
      rmvw_pkg::ST_DONE:  if (out_ready) state_next = rmvw_pkg::ST_IDLE;
      default:            state_next = rmvw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_phase_x <= '0;
      run_phase_y <= '0;
    end else if (in_valid && in_ready) begin
      if (first_vertex) begin
        run_phase_x <= start_phase_x + rmvw_pkg::PHASE_STEP_X;
        run_phase_y <= start_phase_y - rmvw_pkg::PHASE_STEP_Y;
      end else begin
        run_phase_x <= run_phase_x + rmvw_pkg::PHASE_STEP_X;
        run_phase_y <= run_phase_y - rmvw_pkg::PHASE_STEP_Y;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rmvw_pkg::ST_IDLE: begin
        gx     <= grid_x;
        gy     <= grid_y;
        vx     <= vert_x;
        vy     <= vert_y;
        col_in <= vert_color;
        ph_x   <= first_vertex ? start_phase_x : run_phase_x;
        ph_y   <= first_vertex ? start_phase_y : run_phase_y;
        dx     <= 17'(grid_x) - 17'(center_x);
        dy     <= 17'(grid_y) - 17'(center_y);
        dz     <= 17'(grid_z) - 17'(center_z);
        qx     <= '0;
        quo    <= '0;
        wob_x  <= '0;
        wob_y  <= '0;
      end
      rmvw_pkg::ST_MR2: r2 <= mul_p[29:0];
      rmvw_pkg::ST_MDX: d2 <= mul_p;
      rmvw_pkg::ST_MDY: d2 <= d2 + mul_p;
      rmvw_pkg::ST_MDZ: s2 <= d2 + mul_p;
      rmvw_pkg::ST_CHECK: begin
        in_radius <= (d2 <= {4'd0, r2});
        w         <= '0;
        quo       <= '0;
        cnt       <= 5'd16;
        if (r2 == '0) begin
          rem  <= {1'b0, s2};
          res  <= '0;
          bitr <= 33'd1 << 32;
        end else begin
          rem  <= {5'd0, r2 - d2[29:0]};
        end
      end
      rmvw_pkg::ST_DIVW: begin
        if (cnt == '0) begin
          w    <= ge ? {quo[15:0], 1'b1} : {quo[15:0], 1'b0};
          rem  <= {1'b0, s2};
          res  <= '0;
          bitr <= 33'd1 << 32;
          cnt  <= 5'd16;
        end else begin
          if (ge) begin
            rem <= rem_sub << 1;
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= rem << 1;
            quo <= {quo[15:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
        end
      end
      rmvw_pkg::ST_SQRT: begin
        if (ge) begin
          rem <= rem_sub;
          res <= (res >> 1) + {1'b0, bitr};
        end else begin
          res <= res >> 1;
        end
        bitr <= bitr >> 2;
        cnt  <= (cnt == '0) ? 5'd2 : cnt - 5'd1;
        if (cnt == '0) begin
          col_new <= tint_color | rmvw_pkg::ALPHA_FULL;
        end
      end
      rmvw_pkg::ST_MCOL: begin
        col_new <= col_step;
        cnt     <= cnt - 5'd1;
      end
      rmvw_pkg::ST_MPX: px_num <= mul_p[31:7];
      rmvw_pkg::ST_MPY: py_num <= mul_p[31:7];
      rmvw_pkg::ST_MWX: begin
        wob_x <= sine_neg[idx_x] ? -9'(signed'({1'b0, mul_p[30:23]}))
                                 : 9'(signed'({1'b0, mul_p[30:23]}));
      end
      rmvw_pkg::ST_MWY: begin
        wob_y <= sine_neg[idx_y] ? -9'(signed'({1'b0, mul_p[30:23]}))
                                 : 9'(signed'({1'b0, mul_p[30:23]}));
        rem  <= {10'd0, px_num};
        dreg <= {res[16:0], 9'd0};
        quo  <= '0;
        cnt  <= 5'd9;
      end
      rmvw_pkg::ST_DIVX, rmvw_pkg::ST_DIVY: begin
        if (cnt == '0 && state == rmvw_pkg::ST_DIVX) begin
          qx   <= ge ? {quo[8:0], 1'b1} : {quo[8:0], 1'b0};
          quo  <= '0;
          rem  <= {10'd0, py_num};
          dreg <= {res[16:0], 9'd0};
          cnt  <= 5'd9;
        end else begin
          if (ge) begin
            rem <= rem_sub;
            quo <= {quo[15:0], 1'b1};
          end else begin
            quo <= {quo[15:0], 1'b0};
          end
          dreg <= dreg >> 1;
          cnt  <= cnt - 5'd1;
        end
      end
      rmvw_pkg::ST_FINAL: begin
        inside_res <= in_radius;
        out_color  <= in_radius ? col_new : (col_in & rmvw_pkg::RGB_MASK);
        if (gx <= 16'sd0) begin
          out_vert_x <= LOW_EDGE;
          out_grid_x <= LOW_EDGE;
        end else if (17'(gx) >= X_HI) begin
          out_vert_x <= X_EDGE;
          out_grid_x <= X_EDGE;
        end else begin
          out_vert_x <= sat_x;
          out_grid_x <= gx;
        end
        if (gy <= 16'sd0) begin
          out_vert_y <= LOW_EDGE;
          out_grid_y <= LOW_EDGE;
        end else if (17'(gy) >= Y_HI) begin
          out_vert_y <= Y_EDGE;
          out_grid_y <= Y_EDGE;
        end else begin
          out_vert_y <= sat_y;
          out_grid_y <= gy;
        end
      end
      default: ;
    endcase
  end

  `RMVW_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  `RMVW_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready && !out_valid)
  `RMVW_ASSERT_NXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_color))
  `RMVW_ASSERT_IMP(a_outside_alpha, out_valid && !inside_res, out_color[31:24] == 8'd0)

endmodule
`default_nettype wire

/* tb/radial_mesh_vertex_warp_unit_test.sv */
`default_nettype none
module radial_mesh_vertex_warp_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_W     = 640;
  localparam int SCR_H     = 480;
  localparam int LUT_SIZE  = 256;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic               first;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [31:0]        color;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic [31:0]        color;
    logic               in_radius;
  } warped_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic first_vertex = 1'b0;
  logic signed [15:0] grid_x = '0, grid_y = '0, grid_z = '0, vert_x = '0, vert_y = '0;
  logic [31:0] vert_color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_vert_x, out_vert_y, out_grid_x, out_grid_y;
  logic [31:0] out_color;
  logic inside_res;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radial_mesh_vertex_warp_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .first_vertex(first_vertex),
    .grid_x(grid_x), .grid_y(grid_y), .grid_z(grid_z), .vert_x(vert_x), .vert_y(vert_y),
    .vert_color(vert_color), .out_valid(out_valid), .out_ready(out_ready),
    .out_vert_x(out_vert_x), .out_vert_y(out_vert_y), .out_grid_x(out_grid_x),
    .out_grid_y(out_grid_y), .out_color(out_color), .inside_res(inside_res)
  );

  // shadow of the block's registers and running phases
  logic signed [15:0] ctr_x = '0, ctr_y = '0, ctr_z = '0;
  logic [14:0] rad = '0;
  logic [31:0] tint = '0;
  logic [15:0] start_ph_x = '0, start_ph_y = '0;
  logic [15:0] ph_x = '0, ph_y = '0;
  longint sine_lut [LUT_SIZE];

  warped_t warp_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  function automatic longint unsigned sine_series(input longint unsigned x);
    longint unsigned x2, term;
    longint sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  function automatic void build_sine_lut();
    longint unsigned q, r, t, x, v;
    for (int k = 0; k < LUT_SIZE; k++) begin
      q = (4 * k) / LUT_SIZE;
      r = 4 * k - q * LUT_SIZE;
      t = q[0] ? LUT_SIZE - r : r;
      x = (longint'(rmvw_pkg::HALF_PI_Q30) * t) / LUT_SIZE;
      v = (sine_series(x) + 32768) >> 16;
      if (v > 16384) v = 16384;
      sine_lut[k] = (q >= 2) ? -longint'(v) : longint'(v);
    end
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint res, t;
    res = 0;
    for (int b = 18; b >= 0; b--) begin
      t = res | (longint'(1) << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic longint wobble_of(input logic [15:0] ph, input longint w);
    longint idx;
    idx = (longint'(ph) * LUT_SIZE) >> 16;
    return (sine_lut[idx] * w) / (longint'(1) << 23);
  endfunction

  function automatic warped_t warp_vertex(input vertex_t v);
    warped_t r;
    longint gx, gy, dx, dy, dz, d2, r2, diff, w, s2, den, px, py, vx, vy, c, nv;
    logic [31:0] col;
    bit in_radius;
    gx = v.gx; gy = v.gy; vx = v.vx; vy = v.vy;
    col = v.color;
    if (v.first) begin
      ph_x = start_ph_x;
      ph_y = start_ph_y;
    end
    dx = gx - longint'(ctr_x);
    dy = gy - longint'(ctr_y);
    dz = longint'(v.gz) - longint'(ctr_z);
    d2 = dx * dx + dy * dy;
    r2 = longint'(rad) * longint'(rad);
    diff = r2 - d2;
    in_radius = diff >= 0;
    if (!in_radius) begin
      col &= rmvw_pkg::RGB_MASK;
    end else begin
      w = (r2 != 0) ? (diff <<< 16) / r2 : 0;
      col = tint;
      for (int sh = 0; sh <= 16; sh += 8) begin
        c = (col >> sh) & 255;
        nv = 255 - (((255 - c) * w + 65535) >>> 16);
        col[sh +: 8] = nv[7:0];
      end
      col |= rmvw_pkg::ALPHA_FULL;
      s2 = d2 + dz * dz;
      px = 0; py = 0;
      if (s2 != 0) begin
        den = floor_sqrt(s2) <<< 16;
        px = (dx * w * 512) / den;
        py = (dy * w * 512) / den;
      end
      vx += px + wobble_of(ph_x, w);
      vy += py + wobble_of(ph_y, w);
    end
    ph_x = ph_x + rmvw_pkg::PHASE_STEP_X;
    ph_y = ph_y - rmvw_pkg::PHASE_STEP_Y;
    r.vx = sat16(vx);
    r.vy = sat16(vy);
    r.gx = v.gx;
    r.gy = v.gy;
    if (gx <= 0) begin
      r.vx = 16'sd16; r.gx = 16'sd16;
    end else if (gx >= SCR_W * 16) begin
      r.vx = 16'((SCR_W - 1) * 16); r.gx = 16'((SCR_W - 1) * 16);
    end
    if (gy <= 0) begin
      r.vy = 16'sd16; r.gy = 16'sd16;
    end else if (gy >= SCR_H * 16) begin
      r.vy = 16'((SCR_H - 1) * 16); r.gy = 16'((SCR_H - 1) * 16);
    end
    r.color = col;
    r.in_radius = in_radius;
    return r;
  endfunction

  task automatic write_reg(input rmvw_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rmvw_pkg::REG_CENTER_X:   ctr_x = val[15:0];
      rmvw_pkg::REG_CENTER_Y:   ctr_y = val[15:0];
      rmvw_pkg::REG_CENTER_Z:   ctr_z = val[15:0];
      rmvw_pkg::REG_RADIUS:     rad = val[14:0];
      rmvw_pkg::REG_TINT_COLOR: tint = val;
      rmvw_pkg::REG_START_PH_X: start_ph_x = val[15:0];
      rmvw_pkg::REG_START_PH_Y: start_ph_y = val[15:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [15:0] cx, cy, cz, input logic [31:0] r, t,
                       input logic [15:0] spx, spy);
    write_reg(rmvw_pkg::REG_CENTER_X, {16'($urandom), cx});
    write_reg(rmvw_pkg::REG_CENTER_Y, {16'($urandom), cy});
    write_reg(rmvw_pkg::REG_CENTER_Z, {16'($urandom), cz});
    write_reg(rmvw_pkg::REG_RADIUS, r);
    write_reg(rmvw_pkg::REG_TINT_COLOR, t);
    write_reg(rmvw_pkg::REG_START_PH_X, {16'($urandom), spx});
    write_reg(rmvw_pkg::REG_START_PH_Y, {16'($urandom), spy});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (warp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_vertex(input vertex_t v);
    in_valid <= 1'b1;
    first_vertex <= v.first;
    grid_x <= v.gx; grid_y <= v.gy; grid_z <= v.gz;
    vert_x <= v.vx; vert_y <= v.vy;
    vert_color <= v.color;
    do @(posedge clk); while (!in_ready);
    warp_q.push_back(warp_vertex(v));
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 20);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  function automatic vertex_t mk(input logic f, input logic [15:0] gx, gy, gz, vx, vy,
                                 input logic [31:0] col);
    vertex_t v;
    v = {f, gx, gy, gz, vx, vy, col};
    return v;
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t v;
    int span;
    span = int'(rad) + int'(rad) / 4 + 1;
    v.first = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 3) != 0) begin
      v.gx = 16'(ctr_x + $urandom_range(0, 2 * span) - span);
      v.gy = 16'(ctr_y + $urandom_range(0, 2 * span) - span);
      v.gz = 16'(ctr_z + $urandom_range(0, 2 * span) - span);
    end else begin
      v.gx = 16'($urandom); v.gy = 16'($urandom); v.gz = 16'($urandom);
    end
    if ($urandom_range(0, 4) != 0) begin
      v.vx = 16'(v.gx + $urandom_range(0, 64) - 32);
      v.vy = 16'(v.gy + $urandom_range(0, 64) - 32);
    end else begin
      v.vx = 16'($urandom); v.vy = 16'($urandom);
    end
    v.color = $urandom;
    return v;
  endfunction

  task automatic test_directed();
    setup(16'd5120, 16'd3840, 16'd0, 32'd1600, 32'h8040_c0ff, 16'd0, 16'hff00);
    send_vertex(mk(1'b1, 16'd5120, 16'd3840, 16'd0, 16'd5120, 16'd3840, 32'hffff_ffff));
    send_vertex(mk(1'b0, 16'd5120, 16'd3840, 16'd800, 16'd100, 16'd200, 32'h0));
    send_vertex(mk(1'b0, 16'd5920, 16'd3840, 16'd0, 16'h7fff, 16'h7ff0, 32'h1234_5678));
    send_vertex(mk(1'b0, 16'd4320, 16'd3040, 16'h8000, 16'h8000, 16'h8005, 32'hff00_ff00));
    send_vertex(mk(1'b0, 16'd6720, 16'd3840, 16'd0, 16'd1, 16'd2, 32'hffff_ffff));
    send_vertex(mk(1'b0, 16'd0, 16'd0, 16'd0, 16'd300, 16'd300, 32'haaaa_aaaa));
    send_vertex(mk(1'b0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 32'h5555_5555));
    send_vertex(mk(1'b0, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 32'h0));
    send_vertex(mk(1'b0, 16'd10240, 16'd7680, 16'd0, 16'd0, 16'd0, 32'hff00_0000));
    send_vertex(mk(1'b0, 16'd10239, 16'd7679, 16'd0, 16'd5, 16'd5, 32'h00ff_ffff));
    send_vertex(mk(1'b0, 16'd1, 16'd1, 16'd0, 16'd9, 16'd9, 32'h0f0f_0f0f));
    send_vertex(mk(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff));
    drain();
    setup(16'h7fff, 16'h8000, 16'h7fff, 32'h7fff, 32'hffff_ffff, 16'hffff, 16'h8000);
    send_vertex(mk(1'b1, 16'd400, 16'd400, 16'd0, 16'h7fff, 16'h8000, 32'h0));
    send_vertex(mk(1'b0, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 32'h1));
    drain();
    // zero radius: only vertices at the centre's x and y count as inside, whatever their z
    setup(16'd1600, 16'd1600, 16'd16, 32'd0, 32'h0000_0000, 16'd0, 16'd0);
    send_vertex(mk(1'b1, 16'd1600, 16'd1600, 16'd16, 16'd1700, 16'd1500, 32'hdead_beef));
    send_vertex(mk(1'b0, 16'd1600, 16'd1600, 16'd40, 16'd1700, 16'd1500, 32'hdead_beef));
    send_vertex(mk(1'b0, 16'd1601, 16'd1600, 16'd16, 16'd1700, 16'd1500, 32'hcafe_f00d));
    drain();
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: setup(16'd5120, 16'd3840, 16'd0, 32'd2400, $urandom, 16'($urandom),
                 16'($urandom));
        1: setup(16'($urandom_range(0, 10240)), 16'($urandom_range(0, 7680)),
                 16'($urandom), $urandom_range(1, 64), $urandom, 16'($urandom),
                 16'($urandom));
        2: setup(16'h8000, 16'h7fff, 16'h8000, 32'h7fff, 32'h0, 16'h0, 16'hffff);
        3: setup(16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom,
                 16'($urandom), 16'($urandom));
        default: setup(16'($urandom_range(0, 10240)), 16'($urandom_range(0, 7680)),
                       16'($urandom_range(0, 200)), $urandom_range(500, 6000), $urandom,
                       16'($urandom), 16'($urandom));
      endcase
      for (int i = 0; i < 220; i++) send_vertex(random_vertex());
      drain();
    end
  endtask

  task automatic test_backpressure();
    setup(16'd5120, 16'd3840, 16'd0, 32'd3000, $urandom, 16'($urandom), 16'($urandom));
    hold_req = 1;
    burst_left = 40;
    for (int i = 0; i < 40; i++) send_vertex(random_vertex());
    drain();
  endtask

  // receiver: hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_req) begin
      hold_req = 0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= stall_cnt[3];
      endcase
    end
  end

  always @(posedge clk) begin
    warped_t e;
    if (!rst && out_valid && out_ready) begin
      if (warp_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = warp_q.pop_front();
        if (out_vert_x !== e.vx) begin
          $error("out_vert_x: expected %0d, got %0d", e.vx, out_vert_x); errors++;
        end
        if (out_vert_y !== e.vy) begin
          $error("out_vert_y: expected %0d, got %0d", e.vy, out_vert_y); errors++;
        end
        if (out_grid_x !== e.gx) begin
          $error("out_grid_x: expected %0d, got %0d", e.gx, out_grid_x); errors++;
        end
        if (out_grid_y !== e.gy) begin
          $error("out_grid_y: expected %0d, got %0d", e.gy, out_grid_y); errors++;
        end
        if (out_color !== e.color) begin
          $error("out_color: expected %h, got %h", e.color, out_color); errors++;
        end
        if (inside_res !== e.in_radius) begin
          $error("inside_res: expected %0d, got %0d", e.in_radius, inside_res); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    build_sine_lut();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    if (warp_q.size() != 0) begin
      $error("%0d results never arrived", warp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/rmvw_pkg.sv
rtl/radial_mesh_vertex_warp_unit.sv
tb/radial_mesh_vertex_warp_unit_test.sv
